// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define AST_IMPLY(label, clk, rstn, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define AST_NEXT(label, clk, rstn, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/fahq_pkg.sv -----
// Shared types and codes for the five-ary heap queue.
`default_nettype none
package fahq_pkg;
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_DEL_MAX = 2'd1;
    localparam logic [1:0] OP_DEL_MIN = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
endpackage
`default_nettype wire

// ----- rtl/fahq_store.sv -----
// Heap store: single-port-write, single-read synchronous RAM.
`default_nettype none
module fahq_store #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 31,
    parameter int AW    = 9
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/five_ary_max_heap_queue.sv -----
// Top level: five-ary max-heap priority queue with sequencer.
//
// Input beats (s_valid/s_ready) carry s_operation and s_value: insert,
// remove maximum, remove minimum, or the unused code (reports only). Each
// yields one result beat on m_valid/m_ready: removed value, max, min, count, status.
// One operation at a time; s_ready is high only when the sequencer is idle
// and the result register is free or being drained.
// The heap RAM gives one read per cycle; its read data is registered.
//   insert:      read and compare the parent per level climbed, then place the value
//   remove max:  fetch root and last entry, then read the children one by
//                one and write the larger child up per level descended
//   remove min:  a first scan for the minimum, then the same sifts
// Every operation ends with a minimum scan and a read of the root to
// load the result. A failing operation only runs the final scan.
// Reset (aresetn low, synchronous) empties the queue; the RAM is not
// cleared since entries at or above the count are never used.
// When the receiver stalls, the result stays on m_* until taken and no
// new operation is accepted.
`default_nettype none
`include "assert_macros.svh"
module five_ary_max_heap_queue #(
    parameter int CAPACITY   = 512,
    parameter int ARITY      = 5,
    parameter int VALUE_BITS = 31
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_operation,
    input  wire logic [VALUE_BITS-1:0] s_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [VALUE_BITS-1:0]      m_removed_value,
    output logic [VALUE_BITS-1:0]      m_max_value,
    output logic [VALUE_BITS-1:0]      m_min_value,
    output logic [$clog2(CAPACITY+1)-1:0] m_entry_count,
    output logic [1:0]                 m_status
);
    import fahq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int KW = $clog2(ARITY+1);
    // wide enough for pos*ARITY+ARITY
    localparam int XW = $clog2(CAPACITY*(ARITY+1)+1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    // parent index by reciprocal: floor(x/ARITY) = (x*RCP) >> RSH for x < 2^AW
    localparam int RSH = AW + $clog2(ARITY);
    localparam int RCP = ((1 << RSH) + ARITY - 1) / ARITY;
    localparam int PW  = AW + RSH;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FSCAN  = 4'd1;  // find min index for removal
    localparam logic [3:0] S_RDPOS  = 4'd2;  // read removed entry
    localparam logic [3:0] S_RDLAST = 4'd3;  // read last entry
    localparam logic [3:0] S_UPRD   = 4'd4;  // read parent
    localparam logic [3:0] S_UPCMP  = 4'd5;  // compare with parent
    localparam logic [3:0] S_DNRD   = 4'd6;  // read children one by one
    localparam logic [3:0] S_DNSWP  = 4'd7;  // write child up
    localparam logic [3:0] S_RSCAN  = 4'd8;  // final min scan
    localparam logic [3:0] S_RMAX   = 4'd9;  // read root
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [1:0]            op_reg, op_next;
    logic [AW-1:0]         pos_reg, pos_next;       // sifting entry
    logic [VALUE_BITS-1:0] cur_reg, cur_next;       // value being sifted
    logic [CW-1:0]         idx_reg, idx_next;       // scan address
    logic                  rdv_reg, rdv_next;       // read data valid
    logic [CW-1:0]         rdi_reg, rdi_next;       // address of that read
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic [AW-1:0]         besti_reg, besti_next;
    logic                  bestv_reg, bestv_next;
    logic [KW-1:0]         kcnt_reg, kcnt_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [1:0]            st_reg, st_next;
    logic [VALUE_BITS-1:0] max_reg, max_next;
    logic                  mv_reg, mv_next;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata;
    logic [XW-1:0]         first_child;
    logic [PW-1:0]         par_prod;
    logic [AW-1:0]         parent_pos;
    logic                  accept;

    fahq_store #(.DEPTH(CAPACITY), .WIDTH(VALUE_BITS), .AW(AW)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign accept      = s_valid && s_ready;
    assign s_ready     = (state_reg == S_IDLE) && (!mv_reg || m_ready);
    assign first_child = XW'(pos_reg) * XW'(ARITY) + XW'(1);
    assign par_prod    = PW'(pos_reg - AW'(1)) * PW'(RCP);
    assign parent_pos  = par_prod[RSH +: AW];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        rdv_next   = 1'b0;
        rdi_next   = idx_reg;
        best_next  = best_reg;
        besti_next = besti_reg;
        bestv_next = bestv_reg;
        kcnt_next  = kcnt_reg;
        rem_next   = rem_reg;
        st_next    = st_reg;
        max_next   = max_reg;
        mv_next    = mv_reg;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = cur_reg;
        raddr      = idx_reg[AW-1:0];

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next  = s_operation;
                    rem_next = '0;
                    st_next  = ST_OK;
                    idx_next = '0;
                    bestv_next = 1'b0;
                    state_next = S_RSCAN;
                    if (s_operation == OP_INSERT) begin
                        if (count_reg >= CAP_C) begin
                            st_next = ST_FULL;
                        end else begin
                            pos_next   = count_reg[AW-1:0];
                            cur_next   = s_value;
                            count_next = count_reg + CW'(1);
                            state_next = S_UPRD;
                        end
                    end else if (s_operation == OP_DEL_MAX ||
                                 s_operation == OP_DEL_MIN) begin
                        if (count_reg == '0) begin
                            st_next = ST_EMPTY;
                        end else if (s_operation == OP_DEL_MAX) begin
                            pos_next   = '0;
                            state_next = S_RDPOS;
                        end else begin
                            state_next = S_FSCAN;
                        end
                    end
                end
            end
            S_FSCAN, S_RSCAN: begin
                // one read issued per cycle; compare data of previous read
                if (rdv_reg) begin
                    if (!bestv_reg || rdata < best_reg) begin
                        best_next  = rdata;
                        besti_next = rdi_reg[AW-1:0];
                        bestv_next = 1'b1;
                    end
                end
                if (idx_reg < count_reg) begin
                    rdv_next = 1'b1;
                    rdi_next = idx_reg;
                    idx_next = idx_reg + CW'(1);
                end else if (!rdv_reg) begin
                    if (state_reg == S_FSCAN) begin
                        pos_next   = besti_reg;
                        state_next = S_RDPOS;
                    end else begin
                        idx_next   = '0;
                        state_next = S_RMAX;
                    end
                end
            end
            S_RDPOS: begin
                // pos data arrives next; then read last
                raddr = pos_reg;
                if (rdv_reg) begin
                    rem_next   = rdata;
                    state_next = S_RDLAST;
                end else begin
                    rdv_next = 1'b1;
                end
            end
            S_RDLAST: begin
                raddr = AW'(count_reg - CW'(1));
                if (rdv_reg) begin
                    cur_next   = rdata;
                    count_next = count_reg - CW'(1);
                    if (CW'(pos_reg) < count_reg - CW'(1)) begin
                        state_next = S_UPRD;
                    end else begin
                        idx_next   = '0;
                        bestv_next = 1'b0;
                        state_next = S_RSCAN;
                    end
                end else begin
                    rdv_next = 1'b1;
                end
            end
            S_UPRD: begin
                raddr = parent_pos;
                if (pos_reg == '0) begin
                    state_next = (op_reg == OP_INSERT) ? S_RSCAN : S_DNRD;
                    we = (op_reg == OP_INSERT);
                    idx_next = '0;
                    bestv_next = 1'b0;
                    kcnt_next = '0;
                    if (op_reg != OP_INSERT) begin
                        we = 1'b1;
                    end
                end else begin
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (rdata < cur_reg) begin
                    // parent moves down into pos
                    we       = 1'b1;
                    waddr    = pos_reg;
                    wdata    = rdata;
                    pos_next = parent_pos;
                    state_next = S_UPRD;
                end else begin
                    we = 1'b1;
                    if (op_reg == OP_INSERT) begin
                        idx_next   = '0;
                        bestv_next = 1'b0;
                        state_next = S_RSCAN;
                    end else begin
                        kcnt_next  = '0;
                        bestv_next = 1'b0;
                        state_next = S_DNRD;
                    end
                end
            end
            S_DNRD: begin
                // cur is written at pos on entry; scan children
                raddr = AW'(first_child + XW'(kcnt_reg));
                if (rdv_reg) begin
                    if ((!bestv_reg && rdata > cur_reg) ||
                        (bestv_reg && rdata > best_reg)) begin
                        best_next  = rdata;
                        besti_next = rdi_reg[AW-1:0];
                        bestv_next = 1'b1;
                    end
                end
                if (kcnt_reg < KW'(ARITY) &&
                    (first_child + XW'(kcnt_reg)) < XW'(count_reg)) begin
                    rdv_next  = 1'b1;
                    rdi_next  = CW'(first_child + XW'(kcnt_reg));
                    kcnt_next = kcnt_reg + KW'(1);
                end else if (!rdv_reg) begin
                    if (bestv_reg) begin
                        state_next = S_DNSWP;
                    end else begin
                        idx_next   = '0;
                        state_next = S_RSCAN;
                    end
                end
            end
            S_DNSWP: begin
                // child value up to pos; cur follows into the child in S_DNRD
                we         = 1'b1;
                waddr      = pos_reg;
                wdata      = best_reg;
                pos_next   = besti_reg;
                kcnt_next  = '0;
                bestv_next = 1'b0;
                state_next = S_DNRD;
            end
            S_RMAX: begin
                raddr = '0;
                if (rdv_reg) begin
                    max_next   = rdata;
                    state_next = S_DONE;
                end else begin
                    rdv_next = 1'b1;
                end
            end
            S_DONE: begin
                if (!mv_reg) begin
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // the down-swap also writes cur into the child in the following cycle
        if (state_reg == S_DNRD && kcnt_reg == '0 && !rdv_reg) begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
            rdv_reg   <= 1'b0;
            bestv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
            rdv_reg   <= rdv_next;
            bestv_reg <= bestv_next;
        end
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        rdi_reg   <= rdi_next;
        best_reg  <= best_next;
        besti_reg <= besti_next;
        kcnt_reg  <= kcnt_next;
        rem_reg   <= rem_next;
        st_reg    <= st_next;
        max_reg   <= max_next;
    end

    assign m_valid         = mv_reg;
    assign m_removed_value = rem_reg;
    assign m_max_value     = (count_reg == '0) ? '0 : max_reg;
    assign m_min_value     = (count_reg == '0) ? '0 : best_reg;
    assign m_entry_count   = count_reg;
    assign m_status        = st_reg;

    `AST_IMPLY(a_count_cap, aclk, aresetn, 1'b1, count_reg <= CAP_C,
        "count above capacity")
    `AST_IMPLY(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_ready,
        "input ready while busy")
    `AST_NEXT(a_hold_result, aclk, aresetn, mv_reg && !m_ready,
        mv_reg && $stable(count_reg) && $stable(st_reg),
        "result changed while stalled")
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the five-ary max-heap priority queue.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fahq_pkg::*;

    localparam int CAP        = 512;
    localparam int FANOUT     = 5;
    localparam int VBITS      = 31;
    localparam int STALL_MAX  = 9;
    // The watchdog limit is far above the time an item takes at full size.
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 2000;
    // Unused operation code: the block just reports its state.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [VBITS-1:0] VMAX = {VBITS{1'b1}};

    typedef struct packed {
        logic [VBITS-1:0] removed;
        logic [VBITS-1:0] maxv;
        logic [VBITS-1:0] minv;
        logic [9:0]       count;
        logic [1:0]       status;
    } heap_result_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_operation;
    logic [VBITS-1:0] s_value;
    logic             m_valid;
    logic             m_ready;
    logic [VBITS-1:0] m_removed_value;
    logic [VBITS-1:0] m_max_value;
    logic [VBITS-1:0] m_min_value;
    logic [9:0]       m_entry_count;
    logic [1:0]       m_status;

    five_ary_max_heap_queue dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_removed_value (m_removed_value),
        .m_max_value     (m_max_value),
        .m_min_value     (m_min_value),
        .m_entry_count   (m_entry_count),
        .m_status        (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Shadow heap: our own copy of the queue contents and fill level.
    // ---------------------------------------------------------------
    logic [VBITS-1:0] shadow_heap [CAP];
    int               shadow_fill;
    heap_result_t     pending_results[$];

    int  error_count;
    int  beats_sent;
    int  beats_seen;
    int  full_hits;
    int  empty_hits;
    int  idle_cycles;
    bit  stall_enable;   // when clear, both sides run back to back

    function automatic void heap_swap(int a, int b);
        logic [VBITS-1:0] t;
        t              = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = t;
    endfunction

    function automatic void heap_bubble_up(int pos);
        int parent;
        while (pos > 0) begin
            parent = (pos - 1) / FANOUT;
            if (shadow_heap[parent] < shadow_heap[pos]) begin
                heap_swap(parent, pos);
                pos = parent;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void heap_bubble_down(int pos);
        int largest;
        int child;
        while (pos < shadow_fill) begin
            largest = pos;
            // first strictly greater child wins among equal ones
            for (int k = 1; k <= FANOUT; k++) begin
                child = pos * FANOUT + k;
                if (child >= shadow_fill) break;
                if (shadow_heap[child] > shadow_heap[largest]) largest = child;
            end
            if (largest == pos) break;
            heap_swap(pos, largest);
            pos = largest;
        end
    endfunction

    // lowest index among equal minima
    function automatic int heap_min_slot();
        int idx;
        idx = 0;
        for (int i = 1; i < shadow_fill; i++)
            if (shadow_heap[i] < shadow_heap[idx]) idx = i;
        return idx;
    endfunction

    function automatic heap_result_t heap_apply(logic [1:0] op, logic [VBITS-1:0] val);
        heap_result_t r;
        int           slot;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (shadow_fill >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_heap[shadow_fill] = val;
                    shadow_fill++;
                    heap_bubble_up(shadow_fill - 1);
                end
            end
            OP_DEL_MAX, OP_DEL_MIN: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    slot = (op == OP_DEL_MAX) ? 0 : heap_min_slot();
                    r.removed = shadow_heap[slot];
                    shadow_heap[slot] = shadow_heap[shadow_fill - 1];
                    shadow_fill--;
                    if (slot < shadow_fill) begin
                        heap_bubble_up(slot);
                        heap_bubble_down(slot);
                    end
                end
            end
            default: ;
        endcase
        if (shadow_fill > 0) begin
            r.maxv = shadow_heap[0];
            r.minv = shadow_heap[heap_min_slot()];
        end
        r.count = 10'(shadow_fill);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: one beat per call; valid stays up across zero-gap items.
    // ---------------------------------------------------------------
    task automatic send_op(logic [1:0] op, logic [VBITS-1:0] val);
        int gap;
        gap = stall_enable ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_results.push_back(heap_apply(op, val));
        beats_sent++;
        if (op == OP_INSERT && shadow_fill == CAP) full_hits += 0;
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Random value: half the time full range, else a narrow range at either end to force ties.
    function automatic logic [VBITS-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return VBITS'($urandom_range(0, 7));
            1:       return VMAX - VBITS'($urandom_range(0, 3));
            default: return VBITS'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random stall before each result beat.
    // ---------------------------------------------------------------
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = stall_enable ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ---------------------------------------------------------------
    // Result checker: every accepted beat against the oldest prediction.
    // ---------------------------------------------------------------
    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        heap_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat with nothing expected", $time);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                compare_field("removed_value", exp_r.removed, m_removed_value);
                compare_field("max_value",     exp_r.maxv,    m_max_value);
                compare_field("min_value",     exp_r.minv,    m_min_value);
                compare_field("entry_count",   exp_r.count,   m_entry_count);
                compare_field("status",        exp_r.status,  m_status);
                if (exp_r.status == ST_FULL)  full_hits++;
                if (exp_r.status == ST_EMPTY) empty_hits++;
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("five_ary_max_heap_queue: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Removals and the unused code on an empty queue.
    task automatic test_empty_queue();
        send_op(OP_DEL_MAX, VMAX);
        send_op(OP_DEL_MIN, '0);
        send_op(OP_UNUSED, VBITS'($urandom));
        end_burst();
    endtask

    // Value extremes, ties, every operation; sifts through equal keys.
    task automatic test_directed_mix();
        send_op(OP_INSERT, '0);
        send_op(OP_INSERT, VMAX);
        send_op(OP_INSERT, VBITS'(5));
        send_op(OP_INSERT, VBITS'(5));
        send_op(OP_INSERT, VBITS'(5));
        send_op(OP_INSERT, '0);
        send_op(OP_INSERT, VBITS'(31'h5555_5555));
        send_op(OP_INSERT, VBITS'(31'h2AAA_AAAA));
        send_op(OP_UNUSED, VMAX);
        send_op(OP_DEL_MIN, VMAX);
        send_op(OP_DEL_MAX, '0);
        send_op(OP_DEL_MIN, '0);
        send_op(OP_DEL_MAX, '0);
        send_op(OP_DEL_MIN, '0);
        send_op(OP_DEL_MAX, '0);
        send_op(OP_DEL_MIN, '0);
        send_op(OP_DEL_MAX, '0);
        send_op(OP_DEL_MIN, '0);   // goes empty on this or before
        end_burst();
    endtask

    // Sender holds off until every result is back, then continues.
    task automatic test_pause_until_drained();
        for (int i = 0; i < 6; i++) send_op(OP_INSERT, pick_value());
        end_burst();
        wait_results_drained();
        send_op(OP_DEL_MIN, '0);
        send_op(OP_DEL_MAX, '0);
        end_burst();
    endtask

    // Fill to capacity, bounce off full, then take a few entries back out.
    task automatic test_fill_to_capacity();
        while (shadow_fill < CAP) begin
            // stretches without idling on either side
            stall_enable = ((shadow_fill / 80) % 3) != 2;
            send_op(OP_INSERT, pick_value());
        end
        stall_enable = 1'b1;
        send_op(OP_INSERT, VMAX);
        send_op(OP_INSERT, '0);
        send_op(OP_UNUSED, '0);
        while (shadow_fill > CAP - 8)
            send_op($urandom_range(0, 1) ? OP_DEL_MAX : OP_DEL_MIN, VBITS'($urandom));
        end_burst();
    endtask

    // Random traffic, steered toward a target size.
    task automatic test_random_traffic(int n_items);
        int          target;
        int          roll;
        logic [1:0]  op;
        target = 8;
        for (int i = 0; i < n_items; i++) begin
            if (i % 60 == 0) target = $urandom_range(0, 40);
            // stretches without idling on either side
            stall_enable = ((i / 80) % 3) != 2;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                op = OP_UNUSED;
            else if (roll < 4 + (shadow_fill < target ? 60 : 25))
                op = OP_INSERT;
            else
                op = roll[0] ? OP_DEL_MAX : OP_DEL_MIN;
            send_op(op, pick_value());
        end
        stall_enable = 1'b1;
        end_burst();
    endtask

    initial begin
        s_valid      = 1'b0;
        s_operation  = OP_INSERT;
        s_value      = '0;
        aresetn      = 1'b0;
        shadow_fill  = 0;
        error_count  = 0;
        beats_sent   = 0;
        beats_seen   = 0;
        full_hits    = 0;
        empty_hits   = 0;
        idle_cycles  = 0;
        stall_enable = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_directed_mix();
        test_pause_until_drained();
        test_fill_to_capacity();
        test_random_traffic(8);

        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered %0d operations, %0d results checked, incl. full queue at %0d entries",
                 beats_sent, beats_seen, CAP);
        $display("Saw %0d full-queue and %0d empty-queue rejections", full_hits, empty_hits);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("five_ary_max_heap_queue: match");
        end else begin
            $display("five_ary_max_heap_queue: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
